[src/dsh_pkg.sv]
// ----------------------------------------------------------------------------
// dsh_pkg
// Shared types and constants for the diamond-square heightmap generator.
// ----------------------------------------------------------------------------
package dsh_pkg;

  // Bit width of one grid cell height
  localparam int CELL_W       = 4;
  // Cell fields carried by one result row
  localparam int OUT_CELLS    = 9;
  // Default grid edge length
  localparam int ROW_SIZE_DEF = 9;
  // Row number field width
  localparam int ROWNUM_W     = 4;
  // Entries of the queue between front and back
  localparam int QUEUE_DEPTH  = 2;
  // Sum of up to four cells and the count of those cells
  localparam int SUM_W        = 6;
  localparam int CNT_W        = 3;

  // One generate request
  typedef struct packed {
    logic [CELL_W-1:0] corner_top_left;
    logic [CELL_W-1:0] corner_top_right;
    logic [CELL_W-1:0] corner_bottom_left;
    logic [CELL_W-1:0] corner_bottom_right;
  } req_t;

  // One emitted grid row
  typedef struct packed {
    logic [ROWNUM_W-1:0] row_number;
    logic                last_row;
    logic [CELL_W-1:0]   cell_0;
    logic [CELL_W-1:0]   cell_1;
    logic [CELL_W-1:0]   cell_2;
    logic [CELL_W-1:0]   cell_3;
    logic [CELL_W-1:0]   cell_4;
    logic [CELL_W-1:0]   cell_5;
    logic [CELL_W-1:0]   cell_6;
    logic [CELL_W-1:0]   cell_7;
    logic [CELL_W-1:0]   cell_8;
  } row_t;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[src/dsh_ram.sv]
// ----------------------------------------------------------------------------
// dsh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsh_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[src/dsh_front.sv]
// ----------------------------------------------------------------------------
// dsh_front
// Request intake: registers each request transfer and pushes it into the
// job queue when there is room.
// ----------------------------------------------------------------------------
module dsh_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  dsh_pkg::req_t      req,
  input  dsh_pkg::q_status_t q_status,
  output logic               q_push,
  output dsh_pkg::req_t      q_push_data
);
  import dsh_pkg::*;

  logic fr_valid;
  logic fr_valid_next;
  req_t fr_data;
  logic take;

  // Hold off new requests while the register waits on a full queue
  assign req_stall   = fr_valid && q_status.full;
  assign take        = req_valid && !req_stall;
  assign q_push      = fr_valid && !q_status.full;
  assign q_push_data = fr_data;

  always_comb begin
    fr_valid_next = fr_valid;
    if (take) begin
      fr_valid_next = 1'b1;
    end else if (q_push) begin
      fr_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else begin
      fr_valid <= fr_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_data <= req;
    end
  end

endmodule

[src/dsh_fifo.sv]
// ----------------------------------------------------------------------------
// dsh_fifo
// Short job queue between the request front and the generator back end.
// ----------------------------------------------------------------------------
module dsh_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dsh_pkg::req_t      push_data,
  input  logic               pop,
  output dsh_pkg::req_t      pop_data,
  output dsh_pkg::q_status_t status
);
  import dsh_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  req_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign status.full  = (count == CW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = slots[rp];

  // Pointers wrap at the queue depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= push_data;
    end
  end

endmodule

[src/dsh_back.sv]
// ----------------------------------------------------------------------------
// dsh_back
// Generator back end: loads the corners into the row memory, runs the
// square and diamond fills one cell at a time, then reads the grid out
// row by row into the output register.
// ----------------------------------------------------------------------------
module dsh_back #(
  parameter int ROW_SIZE = dsh_pkg::ROW_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dsh_pkg::q_status_t q_status,
  input  dsh_pkg::req_t      q_data,
  output logic               q_pop,
  output logic               row_valid,
  input  logic               row_stall,
  output dsh_pkg::row_t      row
);
  import dsh_pkg::*;

  localparam int AW = $clog2(ROW_SIZE);
  localparam int RW = ROW_SIZE * CELL_W;
  localparam int IW = $clog2(2 * ROW_SIZE);
  localparam logic [IW-1:0] N_I    = IW'(ROW_SIZE);
  localparam logic [IW-1:0] TOP_I  = IW'(ROW_SIZE - 1);
  localparam logic [AW-1:0] LAST_A = AW'(ROW_SIZE - 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_RD0   = 9'b000000100,
    S_RD1   = 9'b000001000,
    S_RD2   = 9'b000010000,
    S_CALC  = 9'b000100000,
    S_WRITE = 9'b001000000,
    S_ORD   = 9'b010000000,
    S_OLD   = 9'b100000000
  } state_t;

  state_t             state;
  state_t             state_next;
  req_t               job;
  logic [AW-1:0]      cr;
  logic [AW-1:0]      orow;
  logic [IW-1:0]      stride;
  logic [IW-1:0]      r;
  logic [IW-1:0]      c;
  logic               is_dia;
  logic               kpar;
  logic [IW-1:0]      stride_next;
  logic [IW-1:0]      r_next;
  logic [IW-1:0]      c_next;
  logic               is_dia_next;
  logic               kpar_next;
  logic               fill_done;
  logic [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]   cnt;
  logic [RW-1:0]      row_hold;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [RW-1:0]      wr_data;
  logic [AW-1:0]      rd_addr;
  logic [RW-1:0]      rd_data;

  logic [IW-1:0]      reach;
  logic [IW-1:0]      r_up;
  logic [IW-1:0]      r_dn;
  logic [IW-1:0]      c_lf;
  logic [IW-1:0]      c_rt;
  logic               up_ok;
  logic               dn_ok;
  logic               lf_ok;
  logic               rt_ok;
  logic [CELL_W-1:0]  cell_mid;
  logic [CELL_W-1:0]  cell_lf;
  logic [CELL_W-1:0]  cell_rt;
  logic               row_ok;
  logic               take_mid;
  logic               take_side;
  logic [SUM_W-1:0]   add_sum;
  logic [CNT_W-1:0]   add_cnt;
  logic [CELL_W-1:0]  mean;
  logic [11:0]        prod3;
  logic               out_load;
  logic [OUT_CELLS-1:0][CELL_W-1:0] cols;

  // Pick the cell at a given column out of a row word
  function automatic logic [CELL_W-1:0] cell_of(input logic [RW-1:0] w,
                                                input logic [IW-1:0] col);
    logic [CELL_W-1:0] v;
    v = '0;
    for (int j = 0; j < ROW_SIZE; j++) begin
      if (col == IW'(j)) begin
        v = w[j*CELL_W +: CELL_W];
      end
    end
    return v;
  endfunction

  // Row memory, one row word per address
  dsh_ram #(
    .WIDTH (RW),
    .DEPTH (ROW_SIZE)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Neighbor positions and grid bounds
  assign reach = stride >> 1;
  assign r_up  = r - reach;
  assign r_dn  = r + reach;
  assign c_lf  = c - reach;
  assign c_rt  = c + reach;
  assign up_ok = (r >= reach);
  assign dn_ok = (r_dn < N_I);
  assign lf_ok = (c >= reach);
  assign rt_ok = (c_rt < N_I);

  // Read address by phase
  always_comb begin
    case (state)
      S_RD0:         rd_addr = up_ok ? r_up[AW-1:0] : r[AW-1:0];
      S_RD1:         rd_addr = dn_ok ? r_dn[AW-1:0] : r[AW-1:0];
      S_RD2:         rd_addr = r[AW-1:0];
      S_ORD, S_OLD:  rd_addr = orow;
      default:       rd_addr = '0;
    endcase
  end

  // Neighbor contributions of the row word now on the read port
  assign cell_mid  = cell_of(rd_data, c);
  assign cell_lf   = cell_of(rd_data, c_lf);
  assign cell_rt   = cell_of(rd_data, c_rt);
  assign row_ok    = ((state == S_RD1) && up_ok) || ((state == S_RD2) && dn_ok)
                     || (state == S_CALC);
  assign take_mid  = row_ok && is_dia && (state != S_CALC);
  assign take_side = row_ok && (is_dia ? (state == S_CALC) : (state != S_CALC));

  always_comb begin
    add_sum = '0;
    add_cnt = '0;
    if (take_mid) begin
      add_sum = add_sum + SUM_W'(cell_mid);
      add_cnt = add_cnt + 1'b1;
    end
    if (take_side && lf_ok) begin
      add_sum = add_sum + SUM_W'(cell_lf);
      add_cnt = add_cnt + 1'b1;
    end
    if (take_side && rt_ok) begin
      add_sum = add_sum + SUM_W'(cell_rt);
      add_cnt = add_cnt + 1'b1;
    end
  end

  // Truncated mean; divide by three as multiply by 43 over 128
  assign prod3 = 12'(sum) * 12'd43;
  always_comb begin
    case (cnt)
      3'd1:    mean = sum[CELL_W-1:0];
      3'd2:    mean = sum[CELL_W:1];
      3'd3:    mean = prod3[10:7];
      3'd4:    mean = sum[CELL_W+1:2];
      default: mean = '0;
    endcase
  end

  // Memory write: corner load during clear, cell update after a fill
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = cr;
      if (cr == '0) begin
        wr_data[0 +: CELL_W]                 = job.corner_top_left;
        wr_data[(ROW_SIZE-1)*CELL_W +: CELL_W] = job.corner_top_right;
      end else if (cr == LAST_A) begin
        wr_data[0 +: CELL_W]                 = job.corner_bottom_left;
        wr_data[(ROW_SIZE-1)*CELL_W +: CELL_W] = job.corner_bottom_right;
      end
    end else if (state == S_WRITE) begin
      wr_en   = 1'b1;
      wr_addr = r[AW-1:0];
      wr_data = row_hold;
      for (int j = 0; j < ROW_SIZE; j++) begin
        if (c == IW'(j)) begin
          wr_data[j*CELL_W +: CELL_W] = mean;
        end
      end
    end
  end

  // Fill order: square centers of a level, then diamond midpoints, then
  // the next level at half the stride
  always_comb begin
    stride_next = stride;
    r_next      = r;
    c_next      = c;
    is_dia_next = is_dia;
    kpar_next   = kpar;
    fill_done   = 1'b0;
    if (!is_dia) begin
      if ((c + stride) < N_I) begin
        c_next = c + stride;
      end else if ((r + stride) < N_I) begin
        c_next = reach;
        r_next = r + stride;
      end else begin
        is_dia_next = 1'b1;
        r_next      = '0;
        kpar_next   = 1'b0;
        c_next      = reach;
      end
    end else begin
      if ((c + stride) < N_I) begin
        c_next = c + stride;
      end else if (r_dn < N_I) begin
        kpar_next = ~kpar;
        c_next    = kpar ? reach : '0;
        r_next    = r_dn;
      end else begin
        stride_next = reach;
        is_dia_next = 1'b0;
        kpar_next   = 1'b0;
        r_next      = reach >> 1;
        c_next      = reach >> 1;
        fill_done   = (reach <= IW'(1));
      end
    end
  end

  // Output row assembly; columns past the grid edge read as zero
  for (genvar j = 0; j < OUT_CELLS; j++) begin : g_col
    if (j < ROW_SIZE) begin : g_in
      assign cols[j] = rd_data[j*CELL_W +: CELL_W];
    end else begin : g_out
      assign cols[j] = '0;
    end
  end

  assign out_load = (state == S_OLD) && (!row_valid || !row_stall);
  assign q_pop    = (state == S_IDLE) && !q_status.empty;

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (!q_status.empty) state_next = S_CLEAR;
      S_CLEAR: if (cr == LAST_A) state_next = S_RD0;
      S_RD0:   state_next = S_RD1;
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = S_CALC;
      S_CALC:  state_next = S_WRITE;
      S_WRITE: state_next = fill_done ? S_ORD : S_RD0;
      S_ORD:   state_next = S_OLD;
      S_OLD: begin
        if (out_load) begin
          state_next = (orow == LAST_A) ? S_IDLE : S_ORD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        row_valid <= 1'b1;
      end else if (!row_stall) begin
        row_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        job <= q_data;
        cr  <= '0;
      end
      S_CLEAR: begin
        cr     <= cr + 1'b1;
        stride <= TOP_I;
        r      <= TOP_I >> 1;
        c      <= TOP_I >> 1;
        is_dia <= 1'b0;
        kpar   <= 1'b0;
      end
      S_RD0: begin
        sum <= '0;
        cnt <= '0;
      end
      S_RD1, S_RD2: begin
        sum <= sum + add_sum;
        cnt <= cnt + add_cnt;
      end
      S_CALC: begin
        sum      <= sum + add_sum;
        cnt      <= cnt + add_cnt;
        row_hold <= rd_data;
      end
      S_WRITE: begin
        stride <= stride_next;
        r      <= r_next;
        c      <= c_next;
        is_dia <= is_dia_next;
        kpar   <= kpar_next;
        orow   <= '0;
      end
      S_OLD: begin
        if (out_load) begin
          orow <= orow + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      row.row_number <= ROWNUM_W'(orow);
      row.last_row   <= (orow == LAST_A);
      row.cell_0     <= cols[0];
      row.cell_1     <= cols[1];
      row.cell_2     <= cols[2];
      row.cell_3     <= cols[3];
      row.cell_4     <= cols[4];
      row.cell_5     <= cols[5];
      row.cell_6     <= cols[6];
      row.cell_7     <= cols[7];
      row.cell_8     <= cols[8];
    end
  end

endmodule

[src/diamond_square_heightmap.sv]
// ----------------------------------------------------------------------------
// diamond_square_heightmap
// Diamond-square heightmap generator: four corner heights in, the filled
// grid out one row per transfer.
//
//   Channel  Dir  Payload  Transfer
//   req      in   req_t    req_valid && !req_stall, one per grid
//   row      out  row_t    row_valid && !row_stall, ROW_SIZE per grid
//
// A grid loads the corner rows, fills each cell through the read, sum and
// write-back states (three row reads, sum, write back through the single read
// port of the row memory), and then reads each output row out of the row memory.
// Reset is synchronous and clears the queue, sequencer and output valid.
// A second request waits in the two-entry queue while a grid is built; a
// stalled row holds the generator until it is taken.
// ----------------------------------------------------------------------------
module diamond_square_heightmap #(
  parameter int ROW_SIZE = dsh_pkg::ROW_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dsh_pkg::req_t req,
  output logic          row_valid,
  input  logic          row_stall,
  output dsh_pkg::row_t row
);
  import dsh_pkg::*;

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  req_t      q_push_data;
  req_t      q_pop_data;

  dsh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  dsh_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .status    (q_status)
  );

  dsh_back #(
    .ROW_SIZE (ROW_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .row_valid (row_valid),
    .row_stall (row_stall),
    .row       (row)
  );

endmodule

[src/dsh_checker.sv]
// ----------------------------------------------------------------------------
// dsh_checker
// Port-level checks on the heightmap generator request and output channels.
// ----------------------------------------------------------------------------
module dsh_checker #(
  parameter int ROW_SIZE = dsh_pkg::ROW_SIZE_DEF
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input dsh_pkg::req_t req,
  input logic          row_valid,
  input logic          row_stall,
  input dsh_pkg::row_t row
);
  import dsh_pkg::*;

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !row_valid)
    else $error("row valid after reset");

  // Row numbers stay inside the grid
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row_valid |-> (row.row_number < ROWNUM_W'(ROW_SIZE)))
    else $error("row number outside grid");

  // Last-row flag marks exactly the bottom row
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    row_valid |-> (row.last_row == (row.row_number == ROWNUM_W'(ROW_SIZE - 1))))
    else $error("last row flag mismatch");

  // A stalled row holds
  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    row_valid && row_stall |=> row_valid && $stable(row))
    else $error("stalled row changed");

  // A stalled request holds its payload
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled request changed");

endmodule

bind diamond_square_heightmap dsh_checker #(
  .ROW_SIZE (ROW_SIZE)
) u_dsh_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .row_valid (row_valid),
  .row_stall (row_stall),
  .row       (row)
);

[tb/sv/diamond_square_heightmap_tb.sv]
// ----------------------------------------------------------------------------
// diamond_square_heightmap_tb
// Self-checking bench for the diamond-square heightmap generator. Corner
// requests go in through a bursty sender. Each 9x9 grid is rebuilt by an
// in-bench model and compared row by row against the output, which runs
// under a random stall pattern. Flat grids are checked against typed-in levels.
// ----------------------------------------------------------------------------
module diamond_square_heightmap_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsh_pkg::*;

  localparam int GRID         = ROW_SIZE_DEF;
  localparam int RANDOM_ITEMS = 115;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int SETTLE       = 60;
  localparam int MAX_REPORTS  = 10;
  // Directed rows without a flat level are checked against the model
  localparam int NOT_FLAT     = -1;
  localparam int DIRECTED_N   = 18;

  // Directed corner sets: TL, TR, BL, BR nibbles from MSB down
  localparam req_t DIRECTED_CORNERS [DIRECTED_N] = '{
    16'h0000, 16'hFFFF, 16'h7777, 16'h8888,
    16'hF000, 16'h0F00, 16'h00F0, 16'h000F,
    16'h0FFF, 16'hF0FF, 16'hFF0F, 16'hFFF0,
    16'hF00F, 16'h0FF0, 16'h1248, 16'h8421,
    16'hA5A5, 16'hEDCB
  };
  localparam int DIRECTED_FLAT [DIRECTED_N] = '{
    0, 15, 7, 8,
    NOT_FLAT, NOT_FLAT, NOT_FLAT, NOT_FLAT,
    NOT_FLAT, NOT_FLAT, NOT_FLAT, NOT_FLAT,
    NOT_FLAT, NOT_FLAT, NOT_FLAT, NOT_FLAT,
    NOT_FLAT, NOT_FLAT
  };

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_HOLD,
    STALL_SPARSE
  } stall_mode_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req       = '0;
  logic        row_valid;
  logic        row_stall = 1'b0;
  row_t        row;

  row_t        expected_rows [$];
  row_t        want_row;
  int          mismatches  = 0;
  int          cycle_count = 0;
  int          burst_left  = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_left  = 0;

  diamond_square_heightmap #(.ROW_SIZE(GRID)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .row_valid (row_valid),
    .row_stall (row_stall),
    .row       (row)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Build the grid for one set of corners and queue its rows.
  // A flat level short-cuts the fill: every cell takes that height.
  function automatic void expect_heightmap(input req_t c, input int flat_level);
    logic [CELL_W-1:0] g [GRID][GRID];
    int   stride, reach, r, col, k, sum, cnt, dr, dc, rr, cc;
    row_t exp_row;
    for (r = 0; r < GRID; r++)
      for (col = 0; col < GRID; col++)
        g[r][col] = (flat_level >= 0) ? CELL_W'(flat_level) : '0;
    if (flat_level < 0) begin
      g[0][0]           = c.corner_top_left;
      g[0][GRID-1]      = c.corner_top_right;
      g[GRID-1][0]      = c.corner_bottom_left;
      g[GRID-1][GRID-1] = c.corner_bottom_right;
      stride = GRID - 1;
      while (stride > 1) begin
        reach = stride / 2;
        // square step: mean of in-grid diagonal corners
        for (r = reach; r < GRID; r += stride)
          for (col = reach; col < GRID; col += stride) begin
            sum = 0;
            cnt = 0;
            for (dr = -1; dr <= 1; dr += 2)
              for (dc = -1; dc <= 1; dc += 2) begin
                rr = r + dr * reach;
                cc = col + dc * reach;
                if (rr >= 0 && rr < GRID && cc >= 0 && cc < GRID) begin
                  sum += g[rr][cc];
                  cnt++;
                end
              end
            g[r][col] = (cnt != 0) ? CELL_W'(sum / cnt) : '0;
          end
        // diamond step: mean of in-grid orthogonal neighbors, updated in place
        k = 0;
        for (r = 0; r < GRID; r += reach) begin
          for (col = (k % 2 == 0) ? reach : 0; col < GRID; col += stride) begin
            sum = 0;
            cnt = 0;
            if (r - reach >= 0) begin
              sum += g[r-reach][col];
              cnt++;
            end
            if (r + reach < GRID) begin
              sum += g[r+reach][col];
              cnt++;
            end
            if (col - reach >= 0) begin
              sum += g[r][col-reach];
              cnt++;
            end
            if (col + reach < GRID) begin
              sum += g[r][col+reach];
              cnt++;
            end
            g[r][col] = (cnt != 0) ? CELL_W'(sum / cnt) : '0;
          end
          k++;
        end
        stride = reach;
      end
    end
    for (r = 0; r < GRID; r++) begin
      exp_row.row_number = ROWNUM_W'(r);
      exp_row.last_row   = (r == GRID - 1);
      exp_row.cell_0     = g[r][0];
      exp_row.cell_1     = g[r][1];
      exp_row.cell_2     = g[r][2];
      exp_row.cell_3     = g[r][3];
      exp_row.cell_4     = g[r][4];
      exp_row.cell_5     = g[r][5];
      exp_row.cell_6     = g[r][6];
      exp_row.cell_7     = g[r][7];
      exp_row.cell_8     = g[r][8];
      expected_rows.push_back(exp_row);
    end
  endfunction

  // Offer one request, wait for the transfer, then maybe end the burst
  task automatic issue_request(input req_t c, input int flat_level);
    int gap;
    req       <= c;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    expect_heightmap(c, flat_level);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 5);
      gap = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(20, 600);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until the whole backlog of rows has drained
  task automatic drain_rows();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_rows.size() != 0);
  endtask

  // Output side: check each row transfer, then pick the next stall value
  always @(posedge clk) begin
    if (!rst && row_valid && !row_stall) begin
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected row: row %0d last %0b cells %h",
                   row.row_number, row.last_row, row[35:0]);
      end else begin
        want_row = expected_rows.pop_front();
        if (row.row_number !== want_row.row_number || row.last_row !== want_row.last_row ||
            row.cell_0 !== want_row.cell_0 || row.cell_1 !== want_row.cell_1 ||
            row.cell_2 !== want_row.cell_2 || row.cell_3 !== want_row.cell_3 ||
            row.cell_4 !== want_row.cell_4 || row.cell_5 !== want_row.cell_5 ||
            row.cell_6 !== want_row.cell_6 || row.cell_7 !== want_row.cell_7 ||
            row.cell_8 !== want_row.cell_8) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("row mismatch: got row %0d last %0b cells %h, exp row %0d last %0b cells %h",
                     row.row_number, row.last_row, row[35:0],
                     want_row.row_number, want_row.last_row, want_row[35:0]);
        end
      end
    end
    // stall pattern: random modes held for random stretches
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(1, 40);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:   row_stall <= 1'b0;
      STALL_COIN:   row_stall <= 1'($urandom_range(0, 1));
      STALL_HOLD:   row_stall <= 1'b1;
      STALL_SPARSE: row_stall <= ($urandom_range(0, 3) == 0);
      default:      row_stall <= 1'b0;
    endcase
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus
  initial begin
    req_t c;
    int   i;
    int   pick;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: flat grids, single hot or cold corners, mixed patterns
    for (i = 0; i < DIRECTED_N; i++)
      issue_request(DIRECTED_CORNERS[i], DIRECTED_FLAT[i]);
    drain_rows();

    // random corner sets, biased toward edges of the height range
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 9);
      c.corner_top_left     = CELL_W'($urandom_range(0, 15));
      c.corner_top_right    = CELL_W'($urandom_range(0, 15));
      c.corner_bottom_left  = CELL_W'($urandom_range(0, 15));
      c.corner_bottom_right = CELL_W'($urandom_range(0, 15));
      if (pick == 0) begin
        c.corner_top_right    = c.corner_top_left;
        c.corner_bottom_left  = c.corner_top_left;
        c.corner_bottom_right = c.corner_top_left;
      end else if (pick <= 2) begin
        c.corner_top_left     = $urandom_range(0, 1) ? 4'hF : 4'h0;
        c.corner_top_right    = $urandom_range(0, 1) ? 4'hF : 4'h0;
        c.corner_bottom_left  = $urandom_range(0, 1) ? 4'hF : 4'h0;
        c.corner_bottom_right = $urandom_range(0, 1) ? 4'hF : 4'h0;
      end
      issue_request(c, NOT_FLAT);
      if (i == RANDOM_ITEMS / 2)
        drain_rows();
    end

    // wind down: let the last grid drain, then a short quiet spell
    drain_rows();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_rows.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
src/dsh_pkg.sv
src/dsh_ram.sv
src/dsh_front.sv
src/dsh_fifo.sv
src/dsh_back.sv
src/diamond_square_heightmap.sv
src/dsh_checker.sv
tb/sv/diamond_square_heightmap_tb.sv
